>>> hw/rtl/clt_pkg.sv
`default_nettype none

package clt_pkg;

  localparam int LineLength = 20;
  localparam int RowCount   = 4;
  localparam int CellCount  = LineLength * RowCount;

  localparam int AddrW   = $clog2(CellCount);
  localparam int CursorW = $clog2(CellCount + 1);
  localparam int ColW    = $clog2(LineLength);

  localparam logic [7:0] SpaceCode   = 8'h20;
  localparam logic [7:0] NewlineCode = 8'h0A;

  localparam logic FuncPut  = 1'b0;
  localparam logic FuncRead = 1'b1;

  // cursor values at the row boundaries
  localparam logic [CursorW-1:0] CurRow1 = CursorW'(LineLength);
  localparam logic [CursorW-1:0] CurRow2 = CursorW'(2 * LineLength);
  localparam logic [CursorW-1:0] CurRow3 = CursorW'(3 * LineLength);
  localparam logic [CursorW-1:0] CurEnd  = CursorW'(CellCount);

  localparam logic [AddrW-1:0] AddrRow0 = AddrW'(0);
  localparam logic [AddrW-1:0] AddrRow1 = AddrW'(LineLength);
  localparam logic [AddrW-1:0] AddrRow2 = AddrW'(2 * LineLength);
  localparam logic [AddrW-1:0] AddrRow3 = AddrW'(3 * LineLength);

  localparam logic [ColW-1:0] ColLast = ColW'(LineLength - 1);

  // scroll copy phases, in the order they must run
  typedef enum logic [1:0] {
    PhRow2To0 = 2'd0,
    PhRow1To2 = 2'd1,
    PhRow3To1 = 2'd2
  } copy_phase_e;

  typedef struct packed {
    logic accept;
    logic copy_rd;
    logic copy_wr;
    logic fill;
    logic load_out;
  } clt_cmd_t;

  typedef struct packed {
    logic is_read;
    logic put_scroll;
    logic seg_last;
    logic phase_last;
  } clt_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/clt_in_if.sv
`default_nettype none

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;
  logic [6:0] cell_index;

  modport source (output valid, output func, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input func, input char_code, input cell_index,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/clt_out_if.sv
`default_nettype none

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [6:0] cursor_pos;
  logic       scrolled;

  modport source (output valid, output read_data, output cursor_pos, output scrolled,
                  input ready);
  modport sink (input valid, input read_data, input cursor_pos, input scrolled,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/clt_ctrl.sv
`default_nettype none

module clt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  clt_pkg::clt_status_t status_i,
  output clt_pkg::clt_cmd_t    cmd_o
);
  import clt_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StCopyRd = 5'b00010,
    StCopyWr = 5'b00100,
    StFill   = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!status_i.is_read && status_i.put_scroll) begin
            state_d = StCopyRd;
          end else begin
            state_d = StDone;
          end
        end
      end
      StCopyRd: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = StCopyWr;
      end
      StCopyWr: begin
        cmd_o.copy_wr = 1'b1;
        if (status_i.seg_last && status_i.phase_last) begin
          state_d = StFill;
        end else begin
          state_d = StCopyRd;
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (status_i.seg_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // hold here while the previous result still sits in the output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/clt_datapath.sv
`default_nettype none

module clt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clt_pkg::clt_cmd_t    cmd_i,
  output clt_pkg::clt_status_t status_o,
  input  logic                 func_i,
  input  logic [7:0]           char_code_i,
  input  logic [6:0]           cell_index_i,
  output logic [7:0]           read_data_o,
  output logic [6:0]           cursor_pos_o,
  output logic                 scrolled_o
);
  import clt_pkg::*;

  // architectural state
  logic [CursorW-1:0] cursor_q;
  logic [ColW-1:0]    col_q;       // cursor_q modulo the line length
  logic [7:0]         prev_q;
  logic               vld_q [CellCount];

  // scroll sequencing
  copy_phase_e        phase_q;
  logic [ColW-1:0]    j_q;
  logic               pend_print_q;
  logic [7:0]         pend_ch_q;

  logic               scr_q;
  logic               rd_ok_q;

  // buffer memory and its read register
  logic [7:0]         mem [CellCount];
  logic [7:0]         rd_data_q;
  logic               rd_vld_q;

  logic [7:0]         out_data_q;
  logic [6:0]         out_cursor_q;
  logic               out_scr_q;

  logic               is_read, in_range, drop;
  logic               at_row1, at_row2, at_row3, at_end, remap;
  logic               is_nl, is_print, wr_ok, put_scroll;
  logic [CursorW-1:0] c1, c2, c3;
  logic [ColW-1:0]    col1, col2, col3;
  logic [AddrW-1:0]   src_base, dst_base, jx;
  logic               we, re;
  logic [AddrW-1:0]   waddr, raddr;
  logic [7:0]         wdata, cell_data;
  copy_phase_e        phase_next;

  assign is_read  = (func_i == FuncRead);
  assign in_range = 32'(cell_index_i) < CellCount;
  // a space at the start of a row is dropped unless it follows a space
  assign drop     = (col_q == '0) && (prev_q != SpaceCode) && (char_code_i == SpaceCode);

  assign at_row1 = (cursor_q == CurRow1);
  assign at_row2 = (cursor_q == CurRow2);
  assign at_row3 = (cursor_q == CurRow3);
  assign at_end  = (cursor_q >= CurEnd);
  assign remap   = at_row1 | at_row2 | at_row3 | at_end;

  // memory rows fill in the order 0, 2, 1, 3
  always_comb begin
    if (at_row1) begin
      c1 = CurRow2;
    end else if (at_row3) begin
      c1 = CurRow1;
    end else if (at_row2 || at_end) begin
      c1 = CurRow3;
    end else begin
      c1 = cursor_q;
    end
  end

  assign col1     = remap ? '0 : col_q;
  assign is_nl    = (char_code_i == NewlineCode);
  assign is_print = !char_code_i[7] && (char_code_i[6:5] != 2'b00);

  assign c2    = is_nl ? c1 + CurRow1 - CursorW'(col1) : c1;
  assign col2  = is_nl ? '0 : col1;
  assign wr_ok = is_print && (c2 < CurEnd);
  assign c3    = wr_ok ? c2 + CursorW'(1) : c2;
  assign col3  = !wr_ok ? col2 : ((col2 == ColLast) ? '0 : col2 + ColW'(1));

  assign put_scroll = !is_read && !drop && at_end;

  assign status_o.is_read    = is_read;
  assign status_o.put_scroll = put_scroll;
  assign status_o.seg_last   = (j_q == ColLast);
  assign status_o.phase_last = (phase_q == PhRow3To1);

  always_comb begin
    src_base   = AddrRow2;
    dst_base   = AddrRow0;
    phase_next = PhRow2To0;
    unique case (phase_q)
      PhRow2To0: begin
        src_base   = AddrRow2;
        dst_base   = AddrRow0;
        phase_next = PhRow1To2;
      end
      PhRow1To2: begin
        src_base   = AddrRow1;
        dst_base   = AddrRow2;
        phase_next = PhRow3To1;
      end
      PhRow3To1: begin
        src_base   = AddrRow3;
        dst_base   = AddrRow1;
        phase_next = PhRow2To0;
      end
      default: begin
        src_base   = AddrRow2;
        dst_base   = AddrRow0;
        phase_next = PhRow2To0;
      end
    endcase
  end

  assign jx        = AddrW'(j_q);
  assign cell_data = rd_vld_q ? rd_data_q : SpaceCode;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.accept && !is_read && !drop && wr_ok && !at_end) begin
      we    = 1'b1;
      waddr = AddrW'(c2);
      wdata = char_code_i;
    end else if (cmd_i.copy_wr) begin
      we    = 1'b1;
      waddr = dst_base + jx;
      wdata = cell_data;
    end else if (cmd_i.fill) begin
      // a printable byte that caused the scroll lands at the head of the new row
      we    = 1'b1;
      waddr = AddrRow3 + jx;
      wdata = ((j_q == '0) && pend_print_q) ? pend_ch_q : SpaceCode;
    end
  end

  assign re    = (cmd_i.accept && is_read && in_range) || cmd_i.copy_rd;
  assign raddr = cmd_i.accept ? AddrW'(cell_index_i) : src_base + jx;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
      rd_vld_q  <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CellCount; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q     <= '0;
      col_q        <= '0;
      prev_q       <= '0;
      phase_q      <= PhRow2To0;
      j_q          <= '0;
      pend_print_q <= 1'b0;
      scr_q        <= 1'b0;
      rd_ok_q      <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rd_ok_q <= is_read && in_range;
        scr_q   <= put_scroll;
        if (!is_read) begin
          prev_q       <= char_code_i;
          pend_print_q <= is_print;
          if (!drop) begin
            cursor_q <= c3;
            col_q    <= col3;
          end
        end
      end
      if (cmd_i.copy_wr) begin
        if (j_q == ColLast) begin
          j_q     <= '0;
          phase_q <= phase_next;
        end else begin
          j_q <= j_q + ColW'(1);
        end
      end
      if (cmd_i.fill) begin
        if (j_q == ColLast) begin
          j_q     <= '0;
          phase_q <= PhRow2To0;
        end else begin
          j_q <= j_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !is_read) begin
      pend_ch_q <= char_code_i;
    end
    if (cmd_i.load_out) begin
      out_data_q   <= rd_ok_q ? cell_data : 8'h00;
      out_cursor_q <= 7'(cursor_q);
      out_scr_q    <= scr_q;
    end
  end

  assign read_data_o  = out_data_q;
  assign cursor_pos_o = out_cursor_q;
  assign scrolled_o   = out_scr_q;

endmodule

`default_nettype wire

>>> hw/rtl/char_lcd_text_terminal_core.sv
`default_nettype none

// channel  dir  fields                              accepted when
// in_i     in   func, char_code[7:0], cell_index[6:0]  valid && ready
// out_o    out  read_data[7:0], cursor_pos[6:0], scrolled  valid && ready
//
// Read or plain put: accept, then the done state loads the output register; in_i.ready
// stays low until that load. Scrolling put: each cell of three rows is copied by a read
// state and a write state, then each cell of the bottom row is cleared before the load.
// Reset: the buffer reads as spaces through per-cell valid flops; no clearing pass.
// in_i.ready stays high while a result waits; the next result then holds in the
// controller until the output register frees.

module char_lcd_text_terminal_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  clt_in_if.sink     in_i,
  clt_out_if.source  out_o
);
  import clt_pkg::*;

  clt_cmd_t    cmd;
  clt_status_t status;

  clt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (in_i.func),
    .char_code_i  (in_i.char_code),
    .cell_index_i (in_i.cell_index),
    .read_data_o  (out_o.read_data),
    .cursor_pos_o (out_o.cursor_pos),
    .scrolled_o   (out_o.scrolled)
  );

endmodule

`default_nettype wire

>>> hw/rtl/clt_checker.sv
`default_nettype none

module clt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_data_i,
  input logic [6:0] cursor_pos_i,
  input logic       scrolled_i
);
  import clt_pkg::*;

  localparam logic [6:0] ScrollCtl = 7'(3 * LineLength);
  localparam logic [6:0] ScrollPut = 7'(3 * LineLength + 1);
  localparam logic [6:0] ScrollNl  = 7'(CellCount);

  // items accepted whose result has not been taken yet
  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(read_data_i) && $stable(cursor_pos_i) && $stable(scrolled_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q != 2'd2)
    else $error("more than two items in flight");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && scrolled_i |->
      cursor_pos_i == ScrollCtl || cursor_pos_i == ScrollPut || cursor_pos_i == ScrollNl)
    else $error("scroll left cursor off the bottom row");

endmodule

bind char_lcd_text_terminal_core clt_checker u_clt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_data_i  (out_o.read_data),
  .cursor_pos_i (out_o.cursor_pos),
  .scrolled_i   (out_o.scrolled)
);

`default_nettype wire

>>> tb/clt_text_checker.sv
`timescale 1ns / 100ps

module clt_text_checker
  import clt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  clt_in_if    in_mon_i,
  clt_out_if   out_mon_i,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   scroll_count_o
);

  // first byte that reads negative as a signed char
  localparam logic [7:0] FirstHighByte = 8'h80;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] cursor_pos;
    logic       scrolled;
  } term_result_t;

  logic [7:0]   shadow_text [CellCount];
  int           shadow_cursor;
  logic [7:0]   shadow_prev;
  term_result_t expected_results [$];

  int mismatches;
  int pending;
  int checked;
  int scrolls;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;
  assign checked_o        = checked;
  assign scroll_count_o   = scrolls;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    scrolls    = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Updates the shadow screen for one item and returns what the block should say.
  function automatic term_result_t predict_item(input logic func, input logic [7:0] ch,
                                                input logic [6:0] idx);
    term_result_t res;
    res = '0;
    if (func == FuncRead) begin
      if (int'(idx) < CellCount) res.read_data = shadow_text[idx];
    end else if ((shadow_cursor % LineLength) == 0 && shadow_prev != SpaceCode &&
                 ch == SpaceCode) begin
      // leading space on a row is swallowed
      shadow_prev = ch;
    end else begin
      shadow_prev = ch;
      if (shadow_cursor == LineLength) begin
        shadow_cursor = 2 * LineLength;
      end else if (shadow_cursor == 3 * LineLength) begin
        shadow_cursor = LineLength;
      end else if (shadow_cursor == 2 * LineLength) begin
        shadow_cursor = 3 * LineLength;
      end else if (shadow_cursor >= 4 * LineLength) begin
        // display lines move up: row2 -> row0, row1 -> row2, row3 -> row1
        shadow_cursor = 3 * LineLength;
        for (int j = 0; j < LineLength; j++) shadow_text[j] = shadow_text[2*LineLength + j];
        for (int j = 0; j < LineLength; j++)
          shadow_text[2*LineLength + j] = shadow_text[LineLength + j];
        for (int j = 0; j < LineLength; j++)
          shadow_text[LineLength + j] = shadow_text[3*LineLength + j];
        for (int j = 0; j < LineLength; j++) shadow_text[3*LineLength + j] = SpaceCode;
        res.scrolled = 1'b1;
      end
      if (ch == NewlineCode) shadow_cursor += LineLength - (shadow_cursor % LineLength);
      if (ch >= SpaceCode && ch < FirstHighByte && shadow_cursor < CellCount) begin
        shadow_text[shadow_cursor] = ch;
        shadow_cursor++;
      end
    end
    res.cursor_pos = 7'(shadow_cursor);
    return res;
  endfunction

  always @(posedge clk_i) begin
    term_result_t want;
    term_result_t got;
    if (!rst_ni) begin
      for (int j = 0; j < CellCount; j++) shadow_text[j] = SpaceCode;
      shadow_cursor = 0;
      shadow_prev   = 8'h00;
      expected_results.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.read_data  = out_mon_i.read_data;
        got.cursor_pos = out_mon_i.cursor_pos;
        got.scrolled   = out_mon_i.scrolled;
        checked++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result: data %02h cursor %0d scrolled %0b",
                                 got.read_data, got.cursor_pos, got.scrolled));
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data)
            report_error($sformatf("result %0d read_data %02h, want %02h",
                                   checked, got.read_data, want.read_data));
          if (got.cursor_pos !== want.cursor_pos)
            report_error($sformatf("result %0d cursor_pos %0d, want %0d",
                                   checked, got.cursor_pos, want.cursor_pos));
          if (got.scrolled !== want.scrolled)
            report_error($sformatf("result %0d scrolled %0b, want %0b",
                                   checked, got.scrolled, want.scrolled));
          if (want.scrolled) scrolls++;
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        expected_results.push_back(predict_item(in_mon_i.func, in_mon_i.char_code,
                                                in_mon_i.cell_index));
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/char_lcd_text_terminal_core_tb.sv
`timescale 1ns / 100ps

module char_lcd_text_terminal_core_tb;
  import clt_pkg::*;

  localparam int RandomItems = 800;
  localparam int HoldCycles  = 300;
  // slowest single item: a scrolling put
  localparam int ScrollLatency = 7 * LineLength + 1;

  logic clk;
  logic rst_n;

  clt_in_if  text_in ();
  clt_out_if term_out ();

  int mismatch_count;
  int pending;
  int checked;
  int scroll_count;

  int   burst_left;
  int   read_count;
  int   put_count;
  logic hold_req;
  int   stall_mode;
  int   mode_left;

  char_lcd_text_terminal_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (text_in),
    .out_o (term_out)
  );

  clt_text_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_mon_i        (text_in),
    .out_mon_i       (term_out),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .scroll_count_o  (scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // bursty sender: random gaps between bursts of random length
  task automatic offer_item(input logic func, input logic [7:0] ch, input logic [6:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        text_in.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    text_in.valid      <= 1'b1;
    text_in.func       <= func;
    text_in.char_code  <= ch;
    text_in.cell_index <= idx;
    do @(posedge clk); while (!text_in.ready);
    if (func == FuncRead) read_count++;
    else put_count++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    text_in.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: stall pattern is picked anew when its random run ends; one long hold-off on request
  initial begin
    term_out.ready = 1'b0;
    mode_left      = 0;
    stall_mode     = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        term_out.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          0: term_out.ready <= 1'b1;
          1: term_out.ready <= ($urandom_range(0, 1) == 1);
          2: term_out.ready <= ($urandom_range(0, 3) == 0);
          default: term_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int         pick;
    logic       f;
    logic [7:0] c;
    logic [6:0] x;

    text_in.valid      = 1'b0;
    text_in.func       = FuncPut;
    text_in.char_code  = 8'h00;
    text_in.cell_index = 7'd0;
    burst_left = 0;
    read_count = 0;
    put_count  = 0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset contents, out-of-range reads, leading spaces, byte classes,
    // newline on and off a boundary, the row interleave and a scroll
    offer_item(FuncRead, 8'hFF, 7'd0);
    offer_item(FuncRead, 8'h00, 7'(CellCount - 1));
    offer_item(FuncRead, 8'h00, 7'(CellCount));
    offer_item(FuncRead, 8'h00, 7'h7F);
    offer_item(FuncPut, SpaceCode, 7'h7F);     // dropped at row start
    offer_item(FuncPut, SpaceCode, 7'd0);      // kept: previous was a space
    offer_item(FuncPut, 8'h41, 7'd0);
    offer_item(FuncPut, 8'h7F, 7'd0);
    offer_item(FuncPut, 8'h7E, 7'd0);
    offer_item(FuncPut, 8'h1F, 7'd0);
    offer_item(FuncPut, 8'h00, 7'd0);
    offer_item(FuncPut, 8'hFF, 7'd0);
    offer_item(FuncPut, 8'h80, 7'd0);
    offer_item(FuncPut, NewlineCode, 7'd0);    // mid row
    offer_item(FuncPut, SpaceCode, 7'd0);      // dropped after newline
    offer_item(FuncPut, NewlineCode, 7'd0);    // on a boundary: full row
    offer_item(FuncPut, 8'h5A, 7'd0);
    offer_item(FuncPut, NewlineCode, 7'd0);
    offer_item(FuncPut, NewlineCode, 7'd0);    // cursor at screen end
    offer_item(FuncPut, 8'h42, 7'd0);          // scrolls
    offer_item(FuncRead, 8'h00, 7'(AddrRow0));
    offer_item(FuncRead, 8'h00, 7'(AddrRow1));
    offer_item(FuncRead, 8'h00, 7'(AddrRow2));
    offer_item(FuncRead, 8'h00, 7'(AddrRow3 + 1));
    wait_for_drain();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 550) wait_for_drain();
      pick = $urandom_range(0, 99);
      f    = FuncPut;
      x    = 7'($urandom_range(0, 127));
      if (pick < 20) begin
        f = FuncRead;
        c = 8'($urandom_range(0, 255));
        x = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(CellCount, 127))
                                         : 7'($urandom_range(0, CellCount - 1));
      end else if (pick < 32) begin
        c = SpaceCode;
      end else if (pick < 40) begin
        c = NewlineCode;
      end else if (pick < 45) begin
        c = 8'($urandom_range(0, 255));
      end else if (pick < 48) begin
        c = 8'($urandom_range(0, 31));
      end else begin
        c = 8'($urandom_range(8'h21, 8'h7E));
      end
      offer_item(f, c, x);
    end

    wait_for_drain();
    repeat (2 * ScrollLatency) @(negedge clk);

    $display("sent %0d puts and %0d reads; %0d results checked, %0d of them scrolled",
             put_count, read_count, checked, scroll_count);
    $display("covered long output hold-off with input backpressure and full drains");
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> char_lcd_text_terminal_core.f
hw/rtl/clt_pkg.sv
hw/rtl/clt_in_if.sv
hw/rtl/clt_out_if.sv
hw/rtl/clt_ctrl.sv
hw/rtl/clt_datapath.sv
hw/rtl/char_lcd_text_terminal_core.sv
hw/rtl/clt_checker.sv
tb/clt_text_checker.sv
tb/char_lcd_text_terminal_core_tb.sv
